@@ rtl/edsw_pkg.sv @@
// Shared types, constants and helpers for the edit distance with swap unit.
package edsw_pkg;

   localparam int MAX_LEN  = 64;
   localparam int LEN_W    = $clog2(MAX_LEN + 1);
   localparam int VAL_W    = LEN_W + 1;
   localparam int UNIT_W   = 16;
   localparam int DIST_W   = 8;
   localparam int DRAIN_W  = $clog2(MAX_LEN + 2);
   localparam int SAT_W    = VAL_W + DIST_W;
   localparam int DIST_MAX = (1 << DIST_W) - 1;

   localparam logic [1:0] FUNC_FIRST  = 2'd0;
   localparam logic [1:0] FUNC_SECOND = 2'd1;
   localparam logic [1:0] FUNC_FINISH = 2'd2;

   // Row update travelling along the cell chain.
   typedef struct packed {
      logic              go;
      logic              init;
      logic              swap_ok;
      logic [UNIT_W-1:0] unit;
      logic [UNIT_W-1:0] prev_unit;
      logic [VAL_W-1:0]  fresh;
      logic [VAL_W-1:0]  last;
      logic [VAL_W-1:0]  before_own;
      logic [VAL_W-1:0]  before_left;
      logic [UNIT_W-1:0] word;
      logic [VAL_W-1:0]  res;
   } wave_type;

   // First-word unit broadcast to the cells.
   typedef struct packed {
      logic              en;
      logic [LEN_W-1:0]  index;
      logic [UNIT_W-1:0] unit;
   } load_type;

   function automatic logic [DIST_W-1:0] sat_dist(input logic [VAL_W-1:0] v);
      logic [SAT_W-1:0] w;
      w = SAT_W'(v);
      if (w > SAT_W'(DIST_MAX)) begin
         return DIST_W'(DIST_MAX);
      end
      return w[DIST_W-1:0];
   endfunction

endpackage

@@ rtl/edsw_cell.sv @@
// One column of the distance row: holds a first-word unit and two row entries.
module edsw_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [edsw_pkg::LEN_W-1:0] cell_index,
   input  logic [edsw_pkg::LEN_W-1:0] first_len,
   input  edsw_pkg::load_type        load,
   input  edsw_pkg::wave_type        left,
   output edsw_pkg::wave_type        right
);
   import edsw_pkg::*;

   logic [UNIT_W-1:0] word_ff;
   logic [VAL_W-1:0]  last_ff;
   logic [VAL_W-1:0]  last_in;
   logic [VAL_W-1:0]  before_ff;
   wave_type          out_ff;
   wave_type          out_in;

   logic [VAL_W-1:0]  last_eff;
   logic [VAL_W-1:0]  del_term;
   logic [VAL_W-1:0]  ins_term;
   logic [VAL_W-1:0]  sub_term;
   logic [VAL_W-1:0]  swap_term;
   logic [VAL_W-1:0]  best;

   always_comb begin
      last_eff  = left.init ? VAL_W'(cell_index) : last_ff;
      del_term  = last_eff + VAL_W'(1);
      ins_term  = left.fresh + VAL_W'(1);
      sub_term  = left.last + VAL_W'(word_ff != left.unit);
      swap_term = left.before_left + VAL_W'(1) + VAL_W'(left.word != word_ff)
                  + VAL_W'(left.prev_unit != left.unit);
      best = (del_term < ins_term) ? del_term : ins_term;
      if (sub_term < best) begin
         best = sub_term;
      end
      if ((cell_index > LEN_W'(2)) && left.swap_ok && (swap_term < best)) begin
         best = swap_term;
      end
      last_in = best;
   end

   always_comb begin
      out_in             = left;
      out_in.fresh       = last_in;
      out_in.last        = last_eff;
      out_in.before_own  = before_ff;
      out_in.before_left = left.before_own;
      out_in.word        = word_ff;
      out_in.res         = (cell_index == first_len) ? last_in : left.res;
   end

   always_ff @(posedge clock) begin
      if (load.en && (load.index == cell_index)) begin
         word_ff <= load.unit;
      end
      if (left.go) begin
         last_ff   <= last_in;
         before_ff <= last_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.go <= 1'b0;
      end else begin
         out_ff <= out_in;
      end
   end

   assign right = out_ff;

endmodule

@@ rtl/edit_distance_with_swap_unit.sv @@
// Top level of the edit distance with swap unit: control, chain of cells, result register.
//
// Request channel (req_valid/req_stall, req_func, req_code_unit):
//   func FIRST appends a unit of the first word while the second is empty, SECOND a unit
//   of the second word, FINISH emits the distance and clears the word state. Other codes
//   are dropped. Units beyond MAX_LEN in either word are dropped and flag too_long.
// Each second-word unit enters a row of MAX_LEN cells and moves one cell per
// cycle, so FIRST and SECOND transactions are taken one per cycle.
// A FINISH waits until the last second-word unit has left the chain. The response is
// registered and shows on rsp_valid in the cycle after the FINISH transaction.
// Response channel (rsp_valid/rsp_stall, rsp_distance, rsp_too_long): the
// response register holds while rsp_stall is high; a FINISH is held off with
// req_stall until that register is free, other transactions keep flowing.
// Reset (synchronous, active high) empties both words, clears the chain and
// drops any pending response. The stored units and row entries are not
// cleared; they are only read once written.
module edit_distance_with_swap_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_func,
   input  logic [edsw_pkg::UNIT_W-1:0] req_code_unit,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [edsw_pkg::DIST_W-1:0] rsp_distance,
   output logic                        rsp_too_long
);
   import edsw_pkg::*;

   logic [LEN_W-1:0]   first_len_ff;
   logic [LEN_W-1:0]   first_len_in;
   logic [LEN_W-1:0]   second_cnt_ff;
   logic [LEN_W-1:0]   second_cnt_in;
   logic [UNIT_W-1:0]  prev_unit_ff;
   logic [UNIT_W-1:0]  prev_unit_in;
   logic               overflow_ff;
   logic               overflow_in;
   logic [DRAIN_W-1:0] drain_ff;
   logic [DRAIN_W-1:0] drain_in;
   wave_type           head_ff;
   wave_type           head_in;
   logic [VAL_W-1:0]   dist_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [DIST_W-1:0]  rsp_distance_ff;
   logic [DIST_W-1:0]  rsp_distance_in;
   logic               rsp_too_long_ff;
   logic               rsp_too_long_in;

   logic      accept;
   logic      acc_first;
   logic      acc_second;
   logic      acc_finish;
   logic      over_first;
   logic      over_second;
   load_type  load;
   wave_type  wave [0:MAX_LEN];

   assign req_stall = (req_func == FUNC_FINISH)
                      && ((drain_ff != '0) || (rsp_valid_ff && rsp_stall));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      acc_first   = accept && (req_func == FUNC_FIRST) && (second_cnt_ff == '0)
                    && (first_len_ff < LEN_W'(MAX_LEN));
      over_first  = accept && (req_func == FUNC_FIRST) && (second_cnt_ff == '0)
                    && (first_len_ff >= LEN_W'(MAX_LEN));
      acc_second  = accept && (req_func == FUNC_SECOND)
                    && (second_cnt_ff < LEN_W'(MAX_LEN));
      over_second = accept && (req_func == FUNC_SECOND)
                    && (second_cnt_ff >= LEN_W'(MAX_LEN));
      acc_finish  = accept && (req_func == FUNC_FINISH);
   end

   always_comb begin
      load.en    = acc_first;
      load.index = first_len_ff + LEN_W'(1);
      load.unit  = req_code_unit;
   end

   always_comb begin
      head_in.go          = acc_second;
      head_in.init        = (second_cnt_ff == '0);
      head_in.swap_ok     = (second_cnt_ff >= LEN_W'(2));
      head_in.unit        = req_code_unit;
      head_in.prev_unit   = prev_unit_ff;
      head_in.fresh       = VAL_W'(second_cnt_ff) + VAL_W'(1);
      head_in.last        = VAL_W'(second_cnt_ff);
      head_in.before_own  = '0;
      head_in.before_left = '0;
      head_in.word        = '0;
      head_in.res         = VAL_W'(second_cnt_ff) + VAL_W'(1);
   end

   always_comb begin
      first_len_in  = first_len_ff;
      second_cnt_in = second_cnt_ff;
      prev_unit_in  = prev_unit_ff;
      overflow_in   = overflow_ff;
      drain_in      = drain_ff;
      if (drain_ff != '0) begin
         drain_in = drain_ff - DRAIN_W'(1);
      end
      if (acc_first) begin
         first_len_in = first_len_ff + LEN_W'(1);
      end
      if (acc_second) begin
         second_cnt_in = second_cnt_ff + LEN_W'(1);
         prev_unit_in  = req_code_unit;
         drain_in      = DRAIN_W'(MAX_LEN + 1);
      end
      if (over_first || over_second) begin
         overflow_in = 1'b1;
      end
      if (acc_finish) begin
         first_len_in  = '0;
         second_cnt_in = '0;
         prev_unit_in  = '0;
         overflow_in   = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_distance_in = rsp_distance_ff;
      rsp_too_long_in = rsp_too_long_ff;
      if (acc_finish) begin
         rsp_valid_in    = 1'b1;
         rsp_distance_in = (second_cnt_ff == '0) ? sat_dist(VAL_W'(first_len_ff))
                                                 : sat_dist(dist_ff);
         rsp_too_long_in = overflow_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_len_ff  <= '0;
         second_cnt_ff <= '0;
         prev_unit_ff  <= '0;
         overflow_ff   <= 1'b0;
         drain_ff      <= '0;
         head_ff.go    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         first_len_ff  <= first_len_in;
         second_cnt_ff <= second_cnt_in;
         prev_unit_ff  <= prev_unit_in;
         overflow_ff   <= overflow_in;
         drain_ff      <= drain_in;
         head_ff       <= head_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_distance_ff <= rsp_distance_in;
      rsp_too_long_ff <= rsp_too_long_in;
      if (wave[MAX_LEN].go) begin
         dist_ff <= wave[MAX_LEN].res;
      end
   end

   assign wave[0] = head_ff;

   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      edsw_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (LEN_W'(i + 1)),
         .first_len  (first_len_ff),
         .load       (load),
         .left       (wave[i]),
         .right      (wave[i + 1])
      );
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_too_long = rsp_too_long_ff;

   a_tail_in_drain: assert property (@(posedge clock) disable iff (reset)
      wave[MAX_LEN].go |-> (drain_ff != '0))
      else $error("row update left the chain outside the drain window");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (first_len_ff <= LEN_W'(MAX_LEN)) && (second_cnt_ff <= LEN_W'(MAX_LEN)))
      else $error("word length beyond MAX_LEN");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      acc_finish |=> (rsp_valid_ff && (first_len_ff == '0) && (second_cnt_ff == '0)
                      && !overflow_ff))
      else $error("finish did not emit and clear");

   a_finish_idle_chain: assert property (@(posedge clock) disable iff (reset)
      acc_finish |-> !head_ff.go && !wave[MAX_LEN].go)
      else $error("finish taken while a row update was in flight");

endmodule

@@ test/edit_distance_with_swap_unit_tb.sv @@
// Testbench for edit_distance_with_swap_unit: random word pairs against a distance tracker.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import edsw_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 1550;
   localparam int TAIL_ITEMS = 150;
   localparam int LONG_HOLD = 400;

   typedef struct {
      logic [1:0]        func;
      logic [UNIT_W-1:0] unit;
   } word_item_type;

   typedef struct {
      logic [DIST_W-1:0] distance;
      logic              too_long;
   } distance_rec_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_func = FUNC_FINISH;
   logic [UNIT_W-1:0]   req_code_unit = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [DIST_W-1:0]   rsp_distance;
   logic                rsp_too_long;

   word_item_type    req_items[$];
   distance_rec_type expected_distances[$];

   // tracked word state
   logic [UNIT_W-1:0] word_a[MAX_LEN];
   int                len_a = 0;
   int                len_b = 0;
   int                row_prev[MAX_LEN+1];
   int                row_prev2[MAX_LEN+1];
   logic [UNIT_W-1:0] last_b = '0;
   bit                long_seen = 1'b0;

   // stimulus alphabet for the word being built
   logic [UNIT_W-1:0] word_syms[4];
   int                syms_used;
   bit                syms_wide;

   int  send_gap = 0;
   int  rsp_gap = 0;
   int  send_rate = 0;
   int  recv_rate = 0;
   int  cycle_count = 0;
   bit  calm_tail = 1'b0;
   int  hold_cycles = 0;
   bit  hold_done = 1'b0;
   int  results_seen = 0;
   int  items_sent = 0;
   int  long_flags = 0;
   int  max_dist = 0;
   int  errors = 0;

   edit_distance_with_swap_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_code_unit (req_code_unit),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_distance  (rsp_distance),
      .rsp_too_long  (rsp_too_long)
   );

   always #10 clock = ~clock;

   task automatic update_words(input logic [1:0] func, input logic [UNIT_W-1:0] unit);
      int               fresh[MAX_LEN+1];
      int               i, k, v, t, d;
      distance_rec_type rec;
      case (func)
         FUNC_FIRST: begin
            if (len_b == 0) begin
               if (len_a >= MAX_LEN) begin
                  long_seen = 1'b1;
               end else begin
                  word_a[len_a] = unit;
                  len_a++;
               end
            end
         end
         FUNC_SECOND: begin
            if (len_b >= MAX_LEN) begin
               long_seen = 1'b1;
            end else begin
               k = len_b + 1;
               if (len_b == 0) begin
                  for (i = 0; i <= len_a; i++) row_prev[i] = i;
               end
               fresh[0] = k;
               for (i = 1; i <= len_a; i++) begin
                  v = row_prev[i] + 1;
                  if (fresh[i-1] + 1 < v) v = fresh[i-1] + 1;
                  if (row_prev[i-1] + (word_a[i-1] != unit) < v)
                     v = row_prev[i-1] + (word_a[i-1] != unit);
                  // transposition term
                  if (i > 2 && k > 2) begin
                     t = row_prev2[i-2] + 1 + (word_a[i-2] != word_a[i-1]) + (last_b != unit);
                     if (t < v) v = t;
                  end
                  fresh[i] = v;
               end
               row_prev2 = row_prev;
               row_prev = fresh;
               last_b = unit;
               len_b = k;
            end
         end
         FUNC_FINISH: begin
            d = (len_b == 0) ? len_a : row_prev[len_a];
            if (d > DIST_MAX) d = DIST_MAX;
            rec.distance = DIST_W'(d);
            rec.too_long = long_seen;
            expected_distances.push_back(rec);
            len_a = 0;
            len_b = 0;
            last_b = '0;
            long_seen = 1'b0;
         end
         default: begin
         end
      endcase
   endtask

   function automatic logic [UNIT_W-1:0] pick_unit();
      if (syms_wide) return UNIT_W'($urandom);
      return word_syms[$urandom_range(0, syms_used - 1)];
   endfunction

   function automatic int pick_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
      return $urandom_range(0, 10);
   endfunction

   task automatic add_item(input logic [1:0] func, input logic [UNIT_W-1:0] unit);
      word_item_type it;
      it.func = func;
      it.unit = unit;
      req_items.push_back(it);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 128 == 0) begin
         send_rate <= $urandom_range(0, 3);
         recv_rate <= $urandom_range(0, 3);
      end
   end

   // driver
   always @(posedge clock) begin
      word_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            update_words(req_func, req_code_unit);
            items_sent <= items_sent + 1;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (!calm_tail && send_rate != 0 && $urandom_range(0, 9) < send_rate) begin
               send_gap <= $urandom_range(0, 7);
               req_valid <= 1'b0;
            end else if (req_items.size() != 0) begin
               it = req_items.pop_front();
               req_valid <= 1'b1;
               req_func <= it.func;
               req_code_unit <= it.unit;
               calm_tail <= (req_items.size() < TAIL_ITEMS);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // one long receiver hold so the response register fills and finish backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
         hold_done <= 1'b0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (!hold_done && results_seen == 20) begin
         hold_cycles <= LONG_HOLD;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      int g;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap <= 0;
      end else begin
         g = rsp_gap;
         if (g != 0) g--;
         else if (!calm_tail && recv_rate != 0 && $urandom_range(0, 9) < recv_rate)
            g = $urandom_range(1, 8);
         rsp_gap <= g;
         rsp_stall <= (g != 0) || (hold_cycles > 1);
      end
   end

   // monitor
   always @(posedge clock) begin
      distance_rec_type rec;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (expected_distances.size() == 0) begin
            if (errors < 10)
               $display("unexpected result: distance %0d too_long %0b", rsp_distance,
                        rsp_too_long);
            errors <= errors + 1;
         end else begin
            rec = expected_distances.pop_front();
            if (rec.too_long) long_flags <= long_flags + 1;
            if (rec.distance > max_dist) max_dist <= rec.distance;
            if (rsp_distance !== rec.distance || rsp_too_long !== rec.too_long) begin
               if (errors < 10)
                  $display("mismatch on result %0d: expected %0d/%0b, got %0d/%0b",
                           results_seen, rec.distance, rec.too_long, rsp_distance,
                           rsp_too_long);
               errors <= errors + 1;
            end
         end
      end
   end

   initial begin
      logic [UNIT_W-1:0] wa[$];
      logic [UNIT_W-1:0] wb[$];
      logic [UNIT_W-1:0] u;
      int pair, na, nb, j, counted;

      // directed transactions
      add_item(FUNC_FINISH, 16'hFFFF);
      add_item(FUNC_FIRST, 16'h0000);
      add_item(FUNC_FIRST, 16'hFFFF);
      add_item(FUNC_FINISH, 16'h0000);
      add_item(FUNC_SECOND, 16'h1234);
      add_item(FUNC_SECOND, 16'hFFFF);
      add_item(FUNC_SECOND, 16'h0000);
      add_item(FUNC_FINISH, 16'h5555);
      add_item(FUNC_FIRST, 16'h0078);
      add_item(FUNC_FIRST, 16'h0061);
      add_item(FUNC_FIRST, 16'h0062);
      add_item(FUNC_SECOND, 16'h0078);
      add_item(FUNC_FIRST, 16'h007A);
      add_item(FUNC_UNUSED, 16'hAAAA);
      add_item(FUNC_SECOND, 16'h0062);
      add_item(FUNC_SECOND, 16'h0061);
      add_item(FUNC_FINISH, 16'hFFFF);
      add_item(FUNC_FIRST, 16'h8000);
      add_item(FUNC_FIRST, 16'h8000);
      add_item(FUNC_FIRST, 16'h8000);
      add_item(FUNC_SECOND, 16'h8000);
      add_item(FUNC_SECOND, 16'h8000);
      add_item(FUNC_SECOND, 16'h8000);
      add_item(FUNC_FINISH, 16'h0001);

      // random word pairs, mostly well-formed
      counted = 24;
      pair = 0;
      while (counted < ITEM_TARGET) begin
         syms_used = $urandom_range(1, 4);
         syms_wide = ($urandom_range(0, 4) == 0) || pair == 2;
         foreach (word_syms[s]) word_syms[s] = UNIT_W'($urandom);
         na = (pair == 0) ? MAX_LEN + 2 : (pair == 2) ? MAX_LEN : pick_len();
         wa.delete();
         repeat (na) wa.push_back(pick_unit());
         wb.delete();
         if (pair != 1 && pair != 2 && $urandom_range(0, 1) == 1) begin
            wb = wa;
            repeat ($urandom_range(0, 3)) begin
               if (wb.size() != 0) begin
                  j = $urandom_range(0, wb.size() - 1);
                  case ($urandom_range(0, 5))
                     0, 1, 2: begin
                        if (j + 1 < wb.size()) begin
                           u = wb[j];
                           wb[j] = wb[j+1];
                           wb[j+1] = u;
                        end
                     end
                     3: wb[j] = pick_unit();
                     4: wb.delete(j);
                     default: wb.insert(j, pick_unit());
                  endcase
               end
            end
         end else begin
            nb = (pair == 1) ? MAX_LEN + 3 : (pair == 2) ? MAX_LEN : pick_len();
            repeat (nb) wb.push_back(pick_unit());
         end
         foreach (wa[i]) begin
            if ($urandom_range(0, 24) == 0) begin
               add_item(FUNC_UNUSED, UNIT_W'($urandom));
               counted++;
            end
            add_item(FUNC_FIRST, wa[i]);
            counted++;
         end
         foreach (wb[i]) begin
            if ($urandom_range(0, 24) == 0) begin
               add_item(FUNC_UNUSED, UNIT_W'($urandom));
               counted++;
            end
            if (i != 0 && $urandom_range(0, 14) == 0) begin
               add_item(FUNC_FIRST, UNIT_W'($urandom));
               counted++;
            end
            add_item(FUNC_SECOND, wb[i]);
            counted++;
         end
         if ($urandom_range(0, 24) != 0 || pair < 3) begin
            add_item(FUNC_FINISH, UNIT_W'($urandom));
            counted++;
         end
         pair++;
      end
      add_item(FUNC_FINISH, UNIT_W'($urandom));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (req_items.size() != 0 || req_valid) @(posedge clock);
      while (expected_distances.size() != 0) @(posedge clock);
      repeat (MAX_LEN + 40) @(posedge clock);

      $display("%0d transactions over %0d word pairs; %0d distances checked", items_sent, pair,
               results_seen);
      $display("%0d results flagged too long, largest distance %0d", long_flags, max_dist);
      if (errors == 0 && expected_distances.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d results outstanding", expected_distances.size());
      $display("testbench NOT OK");
      $finish;
   end

endmodule
